// ===== design/asa_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// asa_pkg
// Shared types and codes for the slot aggregator.
// ----------------------------------------------------------------------------
package asa_pkg;

    localparam logic [1:0] ACT_DROP      = 2'd0;
    localparam logic [1:0] ACT_REFLECT   = 2'd1;
    localparam logic [1:0] ACT_MULTICAST = 2'd2;

    localparam int unsigned FIELD_LANES = 4;
    localparam int unsigned MASK_W      = 4;

    typedef struct packed {
        logic [2:0]  slot;
        logic [2:0]  chunk;
        logic [31:0] exponent;
        logic [3:0]  mask;
        logic [1:0]  bslot;
        logic        ver;
    } hdr_t;

    // controller -> datapath
    typedef struct packed {
        logic capture;
        logic decide;
        logic update;
        logic out_load;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic chunk_zero;
    } stat_t;

endpackage
`default_nettype wire

// ===== design/asa_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// asa_ctrl
// Sequencer: capture, decide (chunk 0), update store, present result.
// ----------------------------------------------------------------------------
module asa_ctrl
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_fire,
    input  wire logic          out_free,
    input  wire asa_pkg::stat_t stat,
    output asa_pkg::cmd_t      cmd,
    output logic               busy
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_DECIDE = 2'd1;
    localparam logic [1:0] S_UPDATE = 2'd2;
    localparam logic [1:0] S_OUT    = 2'd3;

    logic [1:0] state_reg, state_next;

    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                cmd.decide = stat.chunk_zero;
                state_next = S_UPDATE;
            end
            S_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign busy = (state_reg != S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    a_capture_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> state_reg == S_DECIDE) else $error("capture seq");
    a_update_out: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.update |=> state_reg == S_OUT) else $error("update seq");
    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> state_reg == S_IDLE) else $error("load seq");

endmodule
`default_nettype wire

// ===== design/asa_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// asa_datapath
// Bitmaps, counts, exponents and aggregate store; result register.
// ----------------------------------------------------------------------------
module asa_datapath
#(
    parameter int unsigned WORKERS    = 4,
    parameter int unsigned SLOTS      = 4,
    parameter int unsigned SLOT_WORDS = 32,
    parameter int unsigned LANES      = 4
)
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire asa_pkg::cmd_t  cmd,
    output asa_pkg::stat_t      stat,
    input  wire asa_pkg::hdr_t  hdr_in,
    input  wire logic [127:0]   values_in,
    input  wire logic [15:0]    group_cfg,
    output logic [1:0]          act_reg,
    output logic [15:0]         grp_reg,
    output logic [31:0]         expo_reg,
    output logic [2:0]          chunk_reg,
    output logic                last_reg,
    output logic [127:0]        sums_reg
);

    localparam int unsigned NSLOT  = 2 * SLOTS;
    localparam int unsigned SW     = (NSLOT > 1) ? $clog2(NSLOT) : 1;
    localparam int unsigned BW     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int unsigned CW     = $clog2(WORKERS);
    localparam int unsigned CHUNKS = SLOT_WORDS / LANES;
    localparam int unsigned WW     = $clog2(SLOT_WORDS + 8 * asa_pkg::FIELD_LANES);
    localparam int unsigned MW     = asa_pkg::MASK_W;
    localparam logic [MW:0] FULL   = (WORKERS > MW) ? '1 : (MW+1)'((1 << WORKERS) - 1);
    localparam int unsigned AW     = $clog2(NSLOT * SLOT_WORDS);

    asa_pkg::hdr_t hdr_reg;
    logic [127:0]  val_reg;
    logic [SW-1:0] slot_idx;
    logic [BW-1:0] bs_idx;

    logic [MW-1:0] set0_reg [SLOTS];
    logic [MW-1:0] set1_reg [SLOTS];
    logic [CW-1:0] cnt_reg  [NSLOT];
    logic [31:0]   sexp_mem [NSLOT];
    logic [31:0]   agg_mem  [asa_pkg::FIELD_LANES][NSLOT*SLOT_WORDS];
    logic [31:0]   rd_reg   [asa_pkg::FIELD_LANES];

    logic          first_reg, seen_reg;
    logic [1:0]    pact_reg;
    logic [31:0]   pexp_reg;

    // index wrap as small constant tables
    always_comb
    begin
        slot_idx = '0;
        bs_idx   = '0;
        for (int i = 0; i < 8; i++)
            if (hdr_reg.slot == 3'(i))
                slot_idx = SW'(i % NSLOT);
        for (int i = 0; i < 4; i++)
            if (hdr_reg.bslot == 2'(i))
                bs_idx = BW'(i % SLOTS);
    end

    assign stat.chunk_zero = (hdr_reg.chunk == 3'd0);

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            hdr_reg <= hdr_in;
            val_reg <= values_in;
        end
    end

    // decision on chunk 0
    logic [MW-1:0] old_bm;
    logic          seen_c;
    logic [31:0]   sexp_cur, sexp_new;
    logic [CW-1:0] cnt_cur;
    always_comb
    begin
        old_bm   = hdr_reg.ver ? set1_reg[bs_idx] : set0_reg[bs_idx];
        seen_c   = (old_bm & hdr_reg.mask) != '0;
        sexp_cur = sexp_mem[slot_idx];
        cnt_cur  = cnt_reg[slot_idx];
        sexp_new = (!seen_c && hdr_reg.exponent > sexp_cur) ? hdr_reg.exponent : sexp_cur;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                set0_reg[i] <= '0;
                set1_reg[i] <= '0;
            end
            for (int i = 0; i < NSLOT; i++)
                cnt_reg[i] <= '0;
            first_reg <= 1'b0;
            seen_reg  <= 1'b0;
            pact_reg  <= asa_pkg::ACT_DROP;
            pexp_reg  <= '0;
        end
        else if (cmd.decide)
        begin
            if (hdr_reg.ver)
            begin
                set1_reg[bs_idx] <= old_bm | hdr_reg.mask;
                set0_reg[bs_idx] <= set0_reg[bs_idx] & ~hdr_reg.mask;
            end
            else
            begin
                set0_reg[bs_idx] <= old_bm | hdr_reg.mask;
                set1_reg[bs_idx] <= set1_reg[bs_idx] & ~hdr_reg.mask;
            end
            if (old_bm == '0)
            begin
                first_reg         <= 1'b1;
                seen_reg          <= 1'b0;
                pact_reg          <= asa_pkg::ACT_DROP;
                cnt_reg[slot_idx] <= CW'(WORKERS - 1);
                pexp_reg          <= hdr_reg.exponent;
            end
            else
            begin
                first_reg <= 1'b0;
                seen_reg  <= seen_c;
                pexp_reg  <= sexp_new;
                if (!seen_c && cnt_cur != '0)
                    cnt_reg[slot_idx] <= cnt_cur - 1'b1;
                if (cnt_cur == '0)
                    pact_reg <= asa_pkg::ACT_REFLECT;
                else if ({1'b0, old_bm | hdr_reg.mask} == FULL)
                    pact_reg <= asa_pkg::ACT_MULTICAST;
                else
                    pact_reg <= asa_pkg::ACT_DROP;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.decide)
            sexp_mem[slot_idx] <= (old_bm == '0) ? hdr_reg.exponent : sexp_new;
    end

    // aggregate store: one bank per lane, read in DECIDE, written in UPDATE
    logic [WW-1:0] word [asa_pkg::FIELD_LANES];
    logic          wok  [asa_pkg::FIELD_LANES];
    logic [AW-1:0] addr [asa_pkg::FIELD_LANES];
    logic [31:0]   wdat [asa_pkg::FIELD_LANES];
    always_comb
    begin
        for (int l = 0; l < asa_pkg::FIELD_LANES; l++)
        begin
            word[l] = WW'(32'(hdr_reg.chunk) * LANES + l);
            wok[l]  = (l < LANES) && (32'(word[l]) < SLOT_WORDS);
            addr[l] = AW'(32'(word[l]) * NSLOT + 32'(slot_idx));
            wdat[l] = first_reg ? val_reg[32*l +: 32] : rd_reg[l] + val_reg[32*l +: 32];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int l = 0; l < asa_pkg::FIELD_LANES; l++)
        begin
            if (wok[l])
            begin
                if (cmd.decide || !cmd.update)
                    rd_reg[l] <= agg_mem[l][addr[l]];
                if (cmd.update && (first_reg || !seen_reg))
                    agg_mem[l][addr[l]] <= wdat[l];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg <= asa_pkg::ACT_DROP;
            grp_reg <= '0;
        end
        else if (cmd.update)
        begin
            act_reg <= pact_reg;
            grp_reg <= (pact_reg == asa_pkg::ACT_MULTICAST) ? group_cfg : 16'd0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.update)
        begin
            expo_reg  <= pexp_reg;
            chunk_reg <= hdr_reg.chunk;
            last_reg  <= (32'(hdr_reg.chunk) == CHUNKS - 1);
            for (int l = 0; l < asa_pkg::FIELD_LANES; l++)
                sums_reg[32*l +: 32] <= !wok[l] ? 32'd0 :
                    ((first_reg || !seen_reg) ? wdat[l] : rd_reg[l]);
        end
    end

    a_first_drop: assert property (@(posedge clk) disable iff (!rst_n)
        first_reg |-> pact_reg == asa_pkg::ACT_DROP) else $error("first not drop");
    a_first_not_seen: assert property (@(posedge clk) disable iff (!rst_n)
        first_reg |-> !seen_reg) else $error("first and seen");
    a_grp: assert property (@(posedge clk) disable iff (!rst_n)
        act_reg != asa_pkg::ACT_MULTICAST |-> grp_reg == 16'd0) else $error("group");

endmodule
`default_nettype wire

// ===== design/allreduce_slot_aggregator.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// allreduce_slot_aggregator
// Double-buffered slot aggregation of worker packet chunks.
// ----------------------------------------------------------------------------
// Flow: an accepted word is captured, then the sequencer steps through
// DECIDE (store read), UPDATE (store write) and OUT; the output load in OUT
// waits for a free output register. No new word is accepted until IDLE.
// Reset: bitmaps, counts, latched decision cleared; group register = 42.
// Store and slot exponents are undefined until written.
module allreduce_slot_aggregator
#(
    parameter int unsigned WORKERS    = 4,
    parameter int unsigned SLOTS      = 4,
    parameter int unsigned SLOT_WORDS = 32,
    parameter int unsigned LANES      = 4
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         cfg_we,
    input  wire logic [15:0]  cfg_wdata,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // ver, bitmap index, slot, worker_mask, exponent, chunk_index,
    // value_0..value_3; zero pad to 176
    input  wire logic [175:0] s_axis_tdata,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // action, group, exponent_out, chunk_out, sum_0..sum_3; zero pad to 184
    output logic [183:0]      m_axis_tdata,
    output logic              m_axis_tlast
);

    logic [15:0]    group_reg;
    logic           busy, in_fire, out_free, ov_reg;
    asa_pkg::cmd_t  cmd;
    asa_pkg::stat_t stat;
    asa_pkg::hdr_t  hdr;

    logic [1:0]   act_w;
    logic [15:0]  grp_w;
    logic [31:0]  expo_w;
    logic [2:0]   chunk_w;
    logic         last_w;
    logic [127:0] sums_w;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            group_reg <= 16'd42;
        else if (cfg_we)
            group_reg <= cfg_wdata;
    end

    assign s_axis_tready = !busy;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !ov_reg || m_axis_tready;

    assign hdr.ver      = s_axis_tdata[0];
    assign hdr.bslot    = s_axis_tdata[2:1];
    assign hdr.slot     = s_axis_tdata[5:3];
    assign hdr.mask     = s_axis_tdata[9:6];
    assign hdr.exponent = s_axis_tdata[41:10];
    assign hdr.chunk    = s_axis_tdata[44:42];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else if (cmd.out_load)
            ov_reg <= 1'b1;
        else if (m_axis_tready)
            ov_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            m_axis_tdata <= {3'b000, sums_w, chunk_w, expo_w, grp_w, act_w};
            m_axis_tlast <= last_w;
        end
    end

    assign m_axis_tvalid = ov_reg;

    asa_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (in_fire),
        .out_free (out_free),
        .stat     (stat),
        .cmd      (cmd),
        .busy     (busy)
    );

    asa_datapath
    #(
        .WORKERS    (WORKERS),
        .SLOTS      (SLOTS),
        .SLOT_WORDS (SLOT_WORDS),
        .LANES      (LANES)
    )
    u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .hdr_in    (hdr),
        .values_in (s_axis_tdata[172:45]),
        .group_cfg (group_reg),
        .act_reg   (act_w),
        .grp_reg   (grp_w),
        .expo_reg  (expo_w),
        .chunk_reg (chunk_w),
        .last_reg  (last_w),
        .sums_reg  (sums_w)
    );

endmodule
`default_nettype wire
